[rtl/mpe_pkg.sv]
// mpe_pkg: widths, op/mode/read codes, datapath command struct and
// saturation helpers for the motor plant emulator
// no dependencies
`default_nettype none

package mpe_pkg;

  localparam int VAL_W      = 32;
  localparam int FS_W       = 31;
  localparam int KP_W       = 24;
  localparam int ALPHA_W    = 17;
  localparam int MDV_W      = 31;
  localparam int OP_W       = 3;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = 2 * OPND_W;

  // item ops
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_ZERO  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUP   = 3'd4;

  // command modes
  localparam logic [MODE_W-1:0] MODE_DUTY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // read kinds
  localparam logic [KIND_W-1:0] RD_POS     = 3'd0;
  localparam logic [KIND_W-1:0] RD_VEL     = 3'd1;
  localparam logic [KIND_W-1:0] RD_CUR     = 3'd2;
  localparam logic [KIND_W-1:0] RD_FWD_SW  = 3'd3;
  localparam logic [KIND_W-1:0] RD_REV_SW  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_ALPHA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_RPT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_RPT    = 3'd6;

  // multiplier operand selection
  typedef enum logic [1:0] {
    SEL_TGT,
    SEL_DELTA,
    SEL_DT,
    SEL_CUR
  } opnd_sel_t;

  typedef struct packed {
    logic      item_ld;
    logic      wr_cmd;
    logic      zero_enc;
    logic      dup_item;
    logic      opnd_ld;
    opnd_sel_t sel;
    logic      mul_en;
    logic      tgt_en;
    logic      vel_en;
    logic      pos_en;
    logic      res_ld;
  } mpe_cmd_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] x);
    logic fits;
    fits = (&x[PROD_W-1:VAL_W-1]) || (~|x[PROD_W-1:VAL_W-1]);
    if (fits) return x[VAL_W-1:0];
    else if (x[PROD_W-1]) return {1'b1, {(VAL_W-1){1'b0}}};
    else return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // clamp to +-lim, lim non-negative and below 2^31
  function automatic logic signed [VAL_W-1:0] clamp_lim(input logic signed [PROD_W-1:0] x,
                                                        input logic [FS_W-1:0] lim);
    logic signed [PROD_W-1:0] lim_s;
    lim_s = $signed(PROD_W'(lim));
    if (x > lim_s) return $signed({1'b0, lim});
    else if (x < -lim_s) return -$signed({1'b0, lim});
    else return x[VAL_W-1:0];
  endfunction

  // negate, most negative value goes to most positive
  function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] x);
    if (x == {1'b1, {(VAL_W-1){1'b0}}}) return {1'b0, {(VAL_W-1){1'b1}}};
    else return -x;
  endfunction

endpackage

`default_nettype wire

[rtl/mpe_if.sv]
// mpe_in_if / mpe_out_if: valid-ready channels for items and results
// depends on mpe_pkg
`default_nettype none

interface mpe_in_if;
  import mpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [MODE_W-1:0]        cmd_mode;
  logic signed [VAL_W-1:0]  cmd_value;
  logic [KIND_W-1:0]        read_kind;

  modport source (output valid, output op, output cmd_mode, output cmd_value,
                  output read_kind, input ready);
  modport sink (input valid, input op, input cmd_mode, input cmd_value,
                input read_kind, output ready);
endinterface

interface mpe_out_if;
  import mpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  read_value;
  logic                     is_duplicate;

  modport source (output valid, output read_value, output is_duplicate, input ready);
  modport sink (input valid, input read_value, input is_duplicate, output ready);
endinterface

`default_nettype wire

[rtl/mpe_ctrl.sv]
// mpe_ctrl: sequencer for the motor plant emulator, issues datapath commands
// depends on mpe_pkg
`default_nettype none

module mpe_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [mpe_pkg::OP_W-1:0] in_op,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output mpe_pkg::mpe_cmd_t            cmd
);
  import mpe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT_LD,
    S_TGT_MUL,
    S_TGT,
    S_DEL_LD,
    S_DEL_MUL,
    S_VEL,
    S_POS_LD,
    S_POS_MUL,
    S_POS,
    S_RD_LD,
    S_RD_MUL,
    S_RES
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.item_ld  = 1'b1;
          cmd.wr_cmd   = (in_op == OP_WRITE);
          cmd.zero_enc = (in_op == OP_ZERO);
          cmd.dup_item = (in_op == OP_DUP);
          if (in_op == OP_TICK) state_nxt = S_TGT_LD;
          else if (in_op == OP_READ) state_nxt = S_RD_LD;
          else if (in_op == OP_DUP) state_nxt = S_RES;
        end
      end
      S_TGT_LD: begin
        cmd.opnd_ld = 1'b1;
        cmd.sel     = SEL_TGT;
        state_nxt   = S_TGT_MUL;
      end
      S_TGT_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_TGT;
      end
      S_TGT: begin
        cmd.tgt_en = 1'b1;
        state_nxt  = S_DEL_LD;
      end
      S_DEL_LD: begin
        cmd.opnd_ld = 1'b1;
        cmd.sel     = SEL_DELTA;
        state_nxt   = S_DEL_MUL;
      end
      S_DEL_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_VEL;
      end
      S_VEL: begin
        cmd.vel_en = 1'b1;
        state_nxt  = S_POS_LD;
      end
      S_POS_LD: begin
        cmd.opnd_ld = 1'b1;
        cmd.sel     = SEL_DT;
        state_nxt   = S_POS_MUL;
      end
      S_POS_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_POS;
      end
      S_POS: begin
        cmd.pos_en = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD_LD: begin
        cmd.opnd_ld = 1'b1;
        cmd.sel     = SEL_CUR;
        state_nxt   = S_RD_MUL;
      end
      S_RD_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RES;
      end
      S_RES: begin
        // wait here until the output register is free
        if (out_free) begin
          cmd.res_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mpe_datapath.sv]
// mpe_datapath: configuration, motor state, shared multiplier with rounding
// and saturation, result register
// depends on mpe_pkg
`default_nettype none

module mpe_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mpe_pkg::mpe_cmd_t                   cmd,
  input  wire logic                                cfg_we,
  input  wire logic [mpe_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [mpe_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic [mpe_pkg::MODE_W-1:0]          in_cmd_mode,
  input  wire logic signed [mpe_pkg::VAL_W-1:0]    in_cmd_value,
  input  wire logic [mpe_pkg::KIND_W-1:0]          in_read_kind,
  output logic signed [mpe_pkg::VAL_W-1:0]         out_read_value,
  output logic                                     out_is_duplicate
);
  import mpe_pkg::*;

  localparam int ONE_Q   = 1 << FRAC_BITS;
  localparam int DT_Q    = (ONE_Q + 50) / 100;
  localparam int TENTH_Q = (ONE_Q + 5) / 10;
  localparam logic signed [PROD_W-1:0] HALF_Q  = PROD_W'(ONE_Q / 2);
  localparam logic signed [VAL_W-1:0]  NEG_ONE = VAL_W'(-ONE_Q);

  // configuration
  logic [FS_W-1:0]    fs_r;
  logic [KP_W-1:0]    kp_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [MDV_W-1:0]   mdv_r;
  logic               invert_r;
  logic               pos_rpt_r;
  logic               vel_rpt_r;

  // motor state
  logic signed [VAL_W-1:0]  pos_r, pos_nxt;
  logic signed [VAL_W-1:0]  vel_r, vel_nxt;
  logic [MODE_W-1:0]        smode_r;
  logic signed [VAL_W-1:0]  sval_r;

  // latched item
  logic [MODE_W-1:0]        mode_q_r;
  logic signed [VAL_W-1:0]  val_q_r;
  logic [KIND_W-1:0]        kind_q_r;
  // remembers whether the latched item was a duplicate check
  logic                     mode_is_dup_r;

  // arithmetic
  logic signed [OPND_W-1:0] opa_r, opa_nxt;
  logic signed [OPND_W-1:0] opb_r, opb_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] tgt_raw;
  logic signed [VAL_W-1:0]  tgt_r, tgt_nxt;
  logic signed [VAL_W-1:0]  delta;
  logic signed [VAL_W-1:0]  in_val_eff;

  // result
  logic signed [VAL_W-1:0]  res_val_r, res_val_nxt;
  logic                     res_dup_r, res_dup_nxt;

  assign rnd        = (prod_r + HALF_Q) >>> FRAC_BITS;
  assign in_val_eff = invert_r ? neg_sat(in_cmd_value) : in_cmd_value;

  always_comb begin
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    case (cmd.sel)
      SEL_TGT: begin
        if (smode_r == MODE_POS) begin
          opa_nxt = $signed(OPND_W'(kp_r));
          opb_nxt = OPND_W'(sval_r) - OPND_W'(pos_r);
        end else begin
          opa_nxt = OPND_W'(sval_r);
          opb_nxt = $signed(OPND_W'(fs_r));
        end
      end
      SEL_DELTA: begin
        opa_nxt = $signed(OPND_W'(alpha_r));
        opb_nxt = OPND_W'(tgt_r) - OPND_W'(vel_r);
      end
      SEL_DT: begin
        opa_nxt = OPND_W'(vel_r);
        opb_nxt = OPND_W'(DT_Q);
      end
      SEL_CUR: begin
        opa_nxt = vel_r[VAL_W-1] ? -OPND_W'(vel_r) : OPND_W'(vel_r);
        opb_nxt = OPND_W'(TENTH_Q);
      end
      default: begin
        opa_nxt = opa_r;
      end
    endcase
  end

  always_comb begin
    case (smode_r)
      MODE_DUTY, MODE_POS: tgt_raw = rnd;
      MODE_VEL:            tgt_raw = PROD_W'(sval_r);
      default:             tgt_raw = '0;
    endcase
    tgt_nxt = clamp_lim(tgt_raw, fs_r);
    delta   = clamp_lim(rnd, mdv_r);
    vel_nxt = sat_val(PROD_W'(vel_r) + PROD_W'(delta));
    pos_nxt = sat_val(PROD_W'(pos_r) + rnd);
  end

  always_comb begin
    case (kind_q_r)
      RD_POS:    res_val_nxt = pos_rpt_r ? (invert_r ? neg_sat(pos_r) : pos_r) : '0;
      RD_VEL:    res_val_nxt = vel_rpt_r ? (invert_r ? neg_sat(vel_r) : vel_r) : '0;
      RD_CUR:    res_val_nxt = sat_val(rnd);
      RD_FWD_SW,
      RD_REV_SW: res_val_nxt = NEG_ONE;
      default:   res_val_nxt = '0;
    endcase
    res_dup_nxt = (mode_q_r != MODE_NONE) && (mode_q_r == smode_r) && (val_q_r == sval_r);
    // a duplicate check reports only the flag, a read only the value
    if (mode_is_dup_r) res_val_nxt = '0;
    else res_dup_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r      <= '0;
      kp_r      <= '0;
      alpha_r   <= '0;
      mdv_r     <= MDV_W'(ONE_Q);
      invert_r  <= 1'b0;
      pos_rpt_r <= 1'b1;
      vel_rpt_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FREE_SPEED: fs_r      <= cfg_wdata[FS_W-1:0];
        CFG_PROP_GAIN:  kp_r      <= cfg_wdata[KP_W-1:0];
        CFG_LAG_ALPHA:  alpha_r   <= cfg_wdata[ALPHA_W-1:0];
        CFG_MAX_DVEL:   mdv_r     <= cfg_wdata[MDV_W-1:0];
        CFG_INVERT:     invert_r  <= cfg_wdata[0];
        CFG_POS_RPT:    pos_rpt_r <= cfg_wdata[0];
        CFG_VEL_RPT:    vel_rpt_r <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      vel_r   <= '0;
      smode_r <= MODE_DUTY;
      sval_r  <= '0;
    end else begin
      if (cmd.wr_cmd && (in_cmd_mode != MODE_NONE)) begin
        smode_r <= in_cmd_mode;
        sval_r  <= in_val_eff;
      end
      if (cmd.zero_enc) pos_r <= in_val_eff;
      else if (cmd.pos_en) pos_r <= pos_nxt;
      if (cmd.vel_en) vel_r <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      mode_q_r      <= in_cmd_mode;
      val_q_r       <= in_cmd_value;
      kind_q_r      <= in_read_kind;
      mode_is_dup_r <= cmd.dup_item;
    end
    if (cmd.opnd_ld) begin
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
    end
    if (cmd.mul_en) prod_r <= opa_r * opb_r;
    if (cmd.tgt_en) tgt_r <= tgt_nxt;
    if (cmd.res_ld) begin
      res_val_r <= res_val_nxt;
      res_dup_r <= res_dup_nxt;
    end
  end

  assign out_read_value   = res_val_r;
  assign out_is_duplicate = res_dup_r;

endmodule

`default_nettype wire

[rtl/motor_plant_emulator.sv]
// Motor controller and motor emulator in signed fixed point, FRAC_BITS fraction bits.
// Items are taken one at a time. Between a tick's acceptance and the next ready, one
// 33x33 multiplier with registered operands and product is used three times in
// sequence (target, velocity step, position step). A read multiplies first, a
// duplicate check goes straight to its result; a read or duplicate result sits in an
// output register, so the next item is taken while it waits, but a second result
// waits until the first one has been taken. Reset needs no clearing pass.
// depends on mpe_pkg, mpe_if, mpe_ctrl, mpe_datapath
`default_nettype none

module motor_plant_emulator #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mpe_in_if.sink                               in_if,
  mpe_out_if.source                            out_if,
  input  wire logic                            cfg_we,
  input  wire logic [mpe_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [mpe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mpe_pkg::*;

  mpe_cmd_t cmd;

  mpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  mpe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_cmd_mode      (in_if.cmd_mode),
    .in_cmd_value     (in_if.cmd_value),
    .in_read_kind     (in_if.read_kind),
    .out_read_value   (out_if.read_value),
    .out_is_duplicate (out_if.is_duplicate)
  );

endmodule

`default_nettype wire

[tb/tb_motor_plant_emulator.sv]
// tb_motor_plant_emulator: self-checking bench for the motor plant emulator,
// directed table then random phases, each readback checked against a pinned value or a plant predictor
// depends on mpe_pkg, mpe_if and motor_plant_emulator
`timescale 1ns / 100ps

module tb_motor_plant_emulator;
  import mpe_pkg::*;

  localparam int FRAC = 16;
  localparam int ONE_I = 1 << FRAC;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint HALF_Q = longint'(1) << (FRAC - 1);
  localparam longint DT_Q = (ONE_Q + 50) / 100;
  localparam longint TENTH_Q = (ONE_Q + 5) / 10;
  localparam longint MAX_L = 64'sd2147483647;
  localparam longint MIN_L = -64'sd2147483648;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

  // codes the block ignores or answers with zero
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [KIND_W-1:0] RD_ABS = 3'd5;
  localparam logic [KIND_W-1:0] RD_SPARE = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] cmd_mode;
    logic [VAL_W-1:0]  cmd_value;
    logic [KIND_W-1:0] read_kind;
  } plant_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             is_duplicate;
  } plant_res_t;

  typedef struct packed {
    bit         on;
    plant_res_t res;
  } pin_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    plant_item_t            it;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    pin_t                   pin;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mpe_in_if item_ch ();
  mpe_out_if res_ch ();

  motor_plant_emulator #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (item_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted plant state and settings, starting from their reset values
  longint plant_pos = 0;
  longint plant_vel = 0;
  longint cmd_val = 0;
  logic [MODE_W-1:0] cmd_kind = MODE_DUTY;
  longint set_fs = 0;
  longint set_kp = 0;
  longint set_alpha = 0;
  longint set_mdv = ONE_Q;
  bit set_inv = 1'b0;
  bit set_pos_rpt = 1'b1;
  bit set_vel_rpt = 1'b1;

  plant_res_t readback_q[$];
  pin_t pinned_q[$];
  int errs = 0;
  int quiet = 0;
  bit stall_on = 1'b1;

  // last stored command as the stimulus sees it, to aim duplicate checks
  logic [MODE_W-1:0] aim_mode = MODE_DUTY;
  logic [VAL_W-1:0] aim_val = '0;

  function automatic longint mul_q(input longint a, input longint b);
    return (a * b + HALF_Q) >>> FRAC;
  endfunction

  function automatic longint sat_q(input longint x);
    if (x > MAX_L) return MAX_L;
    if (x < MIN_L) return MIN_L;
    return x;
  endfunction

  function automatic longint lim_q(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint flip_q(input longint x, input bit n);
    return n ? sat_q(-x) : x;
  endfunction

  // advance the plant by one item; returns 1 when the item yields a readback
  function automatic bit plant_step(input plant_item_t it, output plant_res_t r);
    longint v;
    longint tgt;
    longint dlt;
    v = longint'($signed(it.cmd_value));
    r = '0;
    case (it.op)
      OP_TICK: begin
        case (cmd_kind)
          MODE_DUTY: tgt = mul_q(cmd_val, set_fs);
          MODE_VEL:  tgt = cmd_val;
          MODE_POS:  tgt = mul_q(set_kp, cmd_val - plant_pos);
          default:   tgt = 0;
        endcase
        tgt = lim_q(tgt, set_fs);
        dlt = lim_q(mul_q(set_alpha, tgt - plant_vel), set_mdv);
        plant_vel = sat_q(plant_vel + dlt);
        plant_pos = sat_q(plant_pos + mul_q(plant_vel, DT_Q));
        return 1'b0;
      end
      OP_WRITE: begin
        if (it.cmd_mode != MODE_SPARE) begin
          cmd_kind = it.cmd_mode;
          cmd_val = flip_q(v, set_inv);
        end
        return 1'b0;
      end
      OP_READ: begin
        case (it.read_kind)
          RD_POS:    v = set_pos_rpt ? flip_q(plant_pos, set_inv) : 0;
          RD_VEL:    v = set_vel_rpt ? flip_q(plant_vel, set_inv) : 0;
          RD_CUR:    v = sat_q(mul_q(plant_vel < 0 ? -plant_vel : plant_vel, TENTH_Q));
          RD_FWD_SW, RD_REV_SW: v = -ONE_Q;
          default:   v = 0;
        endcase
        r.read_value = v[VAL_W-1:0];
        return 1'b1;
      end
      OP_ZERO: begin
        plant_pos = flip_q(v, set_inv);
        return 1'b0;
      end
      OP_DUP: begin
        r.is_duplicate = (it.cmd_mode != MODE_SPARE) && (it.cmd_mode == cmd_kind)
                         && (v == cmd_val);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic plan_row_t item_row(input logic [OP_W-1:0] op,
                                         input logic [MODE_W-1:0] mode,
                                         input logic [VAL_W-1:0] val,
                                         input logic [KIND_W-1:0] kind);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.it = '{op: op, cmd_mode: mode, cmd_value: val, read_kind: kind};
    return row;
  endfunction

  function automatic plan_row_t pinned_row(input logic [OP_W-1:0] op,
                                           input logic [MODE_W-1:0] mode,
                                           input logic [VAL_W-1:0] val,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [VAL_W-1:0] rv,
                                           input logic dup);
    plan_row_t row;
    row = item_row(op, mode, val, kind);
    row.pin = '{on: 1'b1, res: '{read_value: rv, is_duplicate: dup}};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(input logic [MODE_W-1:0] mode);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return Q_MAX;
    if (sel == 1) return Q_MIN;
    if (sel <= 3) return $urandom;
    if (mode == MODE_DUTY) return 32'($urandom_range(2 * ONE_I)) - 32'(ONE_I);
    return 32'($urandom_range(1600 * ONE_I)) - 32'(800 * ONE_I);
  endfunction

  function automatic plant_item_t next_item();
    plant_item_t it;
    int r;
    r = $urandom_range(99);
    it.cmd_mode = ($urandom_range(19) == 0) ? MODE_SPARE : 2'($urandom_range(2));
    it.cmd_value = pick_value(it.cmd_mode);
    it.read_kind = 3'($urandom_range(7));
    if (r < 35) it.op = OP_TICK;
    else if (r < 47) it.op = OP_WRITE;
    else if (r < 77) it.op = OP_READ;
    else if (r < 83) it.op = OP_ZERO;
    else if (r < 95) it.op = OP_DUP;
    else it.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    if (it.op == OP_WRITE && it.cmd_mode != MODE_SPARE) begin
      aim_mode = it.cmd_mode;
      if (!set_inv) aim_val = it.cmd_value;
      else if (it.cmd_value == Q_MIN) aim_val = Q_MAX;
      else aim_val = -it.cmd_value;
    end
    if (it.op == OP_DUP && $urandom_range(9) < 6) begin
      it.cmd_mode = aim_mode;
      it.cmd_value = aim_val;
    end
    return it;
  endfunction

  task automatic push_item(input plant_item_t it, input pin_t pin);
    if (stall_on) begin
      while ($urandom_range(99) < 16) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= it.op;
    item_ch.cmd_mode <= it.cmd_mode;
    item_ch.cmd_value <= it.cmd_value;
    item_ch.read_kind <= it.read_kind;
    pinned_q.push_back(pin);
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // hold the sender until every readback is in and the last tick has finished
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FREE_SPEED: set_fs = longint'(data);
      CFG_PROP_GAIN:  set_kp = longint'(data[KP_W-1:0]);
      CFG_LAG_ALPHA:  set_alpha = longint'(data[ALPHA_W-1:0]);
      CFG_MAX_DVEL:   set_mdv = longint'(data);
      CFG_INVERT:     set_inv = data[0];
      CFG_POS_RPT:    set_pos_rpt = data[0];
      CFG_VEL_RPT:    set_vel_rpt = data[0];
      default: ;
    endcase
  endtask

  // result side stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !stall_on || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin : predict_on_accept
    plant_item_t cur;
    plant_res_t r;
    pin_t pin;
    if (rst_n && item_ch.valid && item_ch.ready) begin
      cur = '{op: item_ch.op, cmd_mode: item_ch.cmd_mode, cmd_value: item_ch.cmd_value,
              read_kind: item_ch.read_kind};
      pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
      if (plant_step(cur, r)) readback_q.push_back(pin.on ? pin.res : r);
    end
  end

  always @(posedge clk) begin : check_readback
    plant_res_t w;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (readback_q.size() == 0) begin
        $error("unexpected result: read_value %0d is_duplicate %0b",
               $signed(res_ch.read_value), res_ch.is_duplicate);
        errs = errs + 1;
      end else begin
        w = readback_q.pop_front();
        if (res_ch.read_value !== w.read_value) begin
          $error("read_value: expected %0d, got %0d", $signed(w.read_value),
                 $signed(res_ch.read_value));
          errs = errs + 1;
        end
        if (res_ch.is_duplicate !== w.is_duplicate) begin
          $error("is_duplicate: expected %0b, got %0b", w.is_duplicate,
                 res_ch.is_duplicate);
          errs = errs + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : main
    plan_row_t plan[$];
    logic [CFG_DATA_W-1:0] regv [7];
    int ph;
    int k;
    int i;

    item_ch.valid = 1'b0;
    item_ch.op = OP_TICK;
    item_ch.cmd_mode = MODE_DUTY;
    item_ch.cmd_value = '0;
    item_ch.read_kind = RD_POS;

    // straight after reset
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, '0, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_VEL, '0, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_CUR, '0, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_FWD_SW, Q_NEG_ONE, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_REV_SW, Q_NEG_ONE, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_ABS, '0, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_SPARE, '0, 1'b0));
    plan.push_back(pinned_row(OP_DUP, MODE_DUTY, '0, RD_POS, '0, 1'b1));
    plan.push_back(pinned_row(OP_DUP, MODE_SPARE, '0, RD_POS, '0, 1'b0));
    // unused mode and unused op leave the stored command alone
    plan.push_back(item_row(OP_WRITE, MODE_SPARE, 32'd1234, RD_POS));
    plan.push_back(item_row(OP_SPARE_HI, MODE_VEL, Q_MAX, RD_SPARE));
    plan.push_back(pinned_row(OP_DUP, MODE_DUTY, '0, RD_POS, '0, 1'b1));
    plan.push_back(item_row(OP_ZERO, MODE_DUTY, Q_MAX, RD_POS));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, Q_MAX, 1'b0));
    plan.push_back(item_row(OP_ZERO, MODE_DUTY, Q_MIN, RD_POS));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, Q_MIN, 1'b0));
    // negating the most negative value saturates
    plan.push_back(reg_row(CFG_INVERT, 31'd1));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, Q_MAX, 1'b0));
    plan.push_back(item_row(OP_ZERO, MODE_DUTY, Q_MIN, RD_POS));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, 32'h8000_0001, 1'b0));
    plan.push_back(item_row(OP_WRITE, MODE_POS, Q_MIN, RD_POS));
    // duplicate check compares the raw value with the stored, negated one
    plan.push_back(pinned_row(OP_DUP, MODE_POS, Q_MAX, RD_POS, '0, 1'b1));
    plan.push_back(reg_row(CFG_FREE_SPEED, 31'h7FFF_FFFF));
    plan.push_back(reg_row(CFG_PROP_GAIN, 31'h00FF_FFFF));
    plan.push_back(reg_row(CFG_LAG_ALPHA, 31'(ONE_I)));
    plan.push_back(reg_row(CFG_MAX_DVEL, 31'h7FFF_FFFF));
    plan.push_back(item_row(OP_WRITE, MODE_DUTY, 32'(ONE_I), RD_POS));
    plan.push_back(item_row(OP_TICK, MODE_DUTY, '0, RD_POS));
    plan.push_back(item_row(OP_READ, MODE_DUTY, '0, RD_VEL));
    plan.push_back(item_row(OP_READ, MODE_DUTY, '0, RD_CUR));
    plan.push_back(reg_row(CFG_POS_RPT, 31'd0));
    plan.push_back(reg_row(CFG_VEL_RPT, 31'd0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_POS, '0, 1'b0));
    plan.push_back(pinned_row(OP_READ, MODE_DUTY, '0, RD_VEL, '0, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_REG) begin
        settle();
        write_reg(plan[n].idx, plan[n].data);
      end else begin
        push_item(plan[n].it, plan[n].pin);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        regv[CFG_FREE_SPEED] = 31'h7FFF_FFFF;
        regv[CFG_PROP_GAIN] = 31'h00FF_FFFF;
        regv[CFG_LAG_ALPHA] = 31'(ONE_I);
        regv[CFG_MAX_DVEL] = 31'h7FFF_FFFF;
        regv[CFG_INVERT] = 31'd0;
        regv[CFG_POS_RPT] = 31'd1;
        regv[CFG_VEL_RPT] = 31'd1;
      end else if (ph == 1) begin
        regv[CFG_FREE_SPEED] = 31'd0;
        regv[CFG_PROP_GAIN] = 31'd0;
        regv[CFG_LAG_ALPHA] = 31'd0;
        regv[CFG_MAX_DVEL] = 31'd0;
        regv[CFG_INVERT] = 31'd1;
        regv[CFG_POS_RPT] = 31'd0;
        regv[CFG_VEL_RPT] = 31'd1;
      end else begin
        regv[CFG_FREE_SPEED] = ($urandom_range(3) == 0) ? 31'($urandom) :
                               31'($urandom_range(800 * ONE_I, 20 * ONE_I));
        regv[CFG_PROP_GAIN] = ($urandom_range(3) == 0) ? 31'($urandom_range(24'hFF_FFFF)) :
                              31'($urandom_range(40 * ONE_I));
        regv[CFG_LAG_ALPHA] = ($urandom_range(4) == 0) ? 31'(ONE_I) :
                              31'($urandom_range(ONE_I));
        regv[CFG_MAX_DVEL] = ($urandom_range(3) == 0) ? 31'($urandom) :
                             31'($urandom_range(50 * ONE_I));
        regv[CFG_INVERT] = 31'($urandom_range(1));
        regv[CFG_POS_RPT] = 31'($urandom_range(3) != 0);
        regv[CFG_VEL_RPT] = 31'($urandom_range(3) != 0);
      end
      for (i = 0; i < 7; i++) write_reg(CFG_IDX_W'(i), regv[i]);
      // one phase runs flat out on both sides
      stall_on = (ph != 3);
      for (k = 0; k < PHASE_ITEMS; k++) push_item(next_item(), '0);
    end

    settle();
    if (errs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
